// File: design/urc_pkg.sv
// shared types and constants for the ultrasonic ranger controller
`default_nettype none

package urc_pkg;

  // field widths
  localparam int unsigned TrigW     = 10;
  localparam int unsigned WaitW     = 20;
  localparam int unsigned RangeW    = 16;
  localparam int unsigned WidthW    = 16;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned CfgIdxW   = 2;

  // register reset values
  localparam logic [TrigW-1:0]  TrigReset  = 10'd10;
  localparam logic [WaitW-1:0]  WaitReset  = 20'd65536;
  localparam logic [RangeW-1:0] RangeReset = 16'd30000;

  // echo width saturates here
  localparam logic [WidthW-1:0] WidthMax = 16'hFFFF;

  // depth of the queue between front and back
  localparam int unsigned FifoDepth = 4;

  // width*100/58 is done as (width*50)/29, the divide by 29 as a reciprocal multiply
  localparam int unsigned  ScaledW    = 22;
  localparam int unsigned  DistW      = 17;
  localparam int unsigned  RecipW     = 23;
  localparam logic [ScaledW-1:0] ScaleMul = 22'd50;
  localparam logic [RecipW-1:0]  RecipMul = 23'd4628198;
  localparam int unsigned  RecipShift = 27;

  // divide by ten, exact for any 16-bit value
  localparam int unsigned  TenW     = 16;
  localparam logic [TenW-1:0] TenMul = 16'd52429;
  localparam int unsigned  TenShift = 19;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTrigger = 2'd0,
    CfgWait    = 2'd1,
    CfgRange   = 2'd2
  } cfg_idx_e;

  // what one tick reports
  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindEcho    = 2'd1,
    KindTimeout = 2'd2
  } kind_e;

  // classified tick handed from front to back
  typedef struct packed {
    logic              trig;
    kind_e             kind;
    logic [WidthW-1:0] width;
  } item_t;

endpackage

`default_nettype wire

// File: design/urc_front.sv
// front part: trigger sequencing and echo pulse measurement, one tick per beat
`default_nettype none

module urc_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic                         echo_i,
  input  wire logic [urc_pkg::TrigW-1:0]    trigger_ticks_i,
  input  wire logic [urc_pkg::WaitW-1:0]    wait_ticks_i,
  input  wire logic                         q_full_i,
  output      logic                         q_push_o,
  output      urc_pkg::item_t               q_item_o
);

  logic                        in_trig_q, in_trig_d;
  logic [urc_pkg::WaitW-1:0]   phase_cnt_q, phase_cnt_d;
  logic                        echo_seen_q, echo_seen_d;
  logic                        echo_prev_q, echo_prev_d;
  logic [urc_pkg::WidthW-1:0]  width_q, width_d;

  logic                        accept;
  logic                        falling;
  logic [urc_pkg::WaitW-1:0]   cnt_inc;
  logic                        wait_end;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  // echo pulse measurement
  assign falling = !echo_i && echo_prev_q;

  always_comb begin
    width_d = width_q;
    if (echo_i) begin
      if (!echo_prev_q) begin
        width_d = urc_pkg::WidthW'(1);
      end else if (width_q != urc_pkg::WidthMax) begin
        width_d = width_q + urc_pkg::WidthW'(1);
      end
    end
  end

  // trigger sequencing
  assign cnt_inc  = phase_cnt_q + urc_pkg::WaitW'(1);
  assign wait_end = !in_trig_q && (cnt_inc >= wait_ticks_i);

  always_comb begin
    in_trig_d   = in_trig_q;
    phase_cnt_d = cnt_inc;
    echo_seen_d = echo_seen_q || falling;
    if (in_trig_q) begin
      if (cnt_inc >= {{(urc_pkg::WaitW-urc_pkg::TrigW){1'b0}}, trigger_ticks_i}) begin
        in_trig_d   = 1'b0;
        phase_cnt_d = '0;
      end
    end else if (wait_end) begin
      in_trig_d   = 1'b1;
      phase_cnt_d = '0;
      echo_seen_d = 1'b0;
    end
  end

  assign echo_prev_d = echo_i;

  // classify the tick
  always_comb begin
    q_item_o.trig  = in_trig_q;
    q_item_o.width = width_q;
    priority if (falling) begin
      q_item_o.kind = urc_pkg::KindEcho;
    end else if (wait_end && !echo_seen_q) begin
      q_item_o.kind = urc_pkg::KindTimeout;
    end else begin
      q_item_o.kind = urc_pkg::KindNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_trig_q   <= 1'b1;
      phase_cnt_q <= '0;
      echo_seen_q <= 1'b0;
      echo_prev_q <= 1'b0;
      width_q     <= '0;
    end else if (accept) begin
      in_trig_q   <= in_trig_d;
      phase_cnt_q <= phase_cnt_d;
      echo_seen_q <= echo_seen_d;
      echo_prev_q <= echo_prev_d;
      width_q     <= width_d;
    end
  end

endmodule

`default_nettype wire

// File: design/urc_fifo.sv
// short flip-flop queue between the front and back parts
`default_nettype none

module urc_fifo #(
  parameter int unsigned Depth = urc_pkg::FifoDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire urc_pkg::item_t item_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           empty_o,
  output      urc_pkg::item_t item_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  urc_pkg::item_t     mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/urc_back.sv
// back part: distance scaling, range check and decimal digits, pipelined
`default_nettype none

module urc_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire urc_pkg::item_t               q_item_i,
  output      logic                         q_pop_o,
  input  wire logic [urc_pkg::RangeW-1:0]   max_range_i,
  input  wire logic                         pop_i,
  output      logic                         empty_o,
  output      logic                         trig_o,
  output      logic                         res_valid_o,
  output      logic [urc_pkg::RangeW-1:0]   dist_o,
  output      logic                         oor_o,
  output      logic                         tmo_o,
  output      logic [urc_pkg::DigitW-1:0]   digits_o [urc_pkg::NumDigits]
);

  localparam int unsigned NumDivStages = urc_pkg::NumDigits - 1;
  localparam int unsigned NumStages    = 3 + NumDivStages;
  localparam int unsigned ProdW        = urc_pkg::ScaledW + urc_pkg::RecipW;
  localparam int unsigned TenProdW     = urc_pkg::RangeW + urc_pkg::TenW;

  logic [NumStages-1:0] vld_q;
  logic                 adv;

  // stage 1: width * 50
  logic                         s1_trig_q;
  urc_pkg::kind_e               s1_kind_q;
  logic [urc_pkg::ScaledW-1:0]  s1_x_q;
  // stage 2: divide by 29
  logic                         s2_trig_q;
  urc_pkg::kind_e               s2_kind_q;
  logic [urc_pkg::DistW-1:0]    s2_d_q;
  logic [ProdW-1:0]             s2_prod;
  // stage 3: range check and result select
  logic                         s3_trig_q, s3_trig_d;
  logic                         s3_vres_q, s3_vres_d;
  logic [urc_pkg::RangeW-1:0]   s3_dist_q, s3_dist_d;
  logic                         s3_oor_q, s3_oor_d;
  logic                         s3_tmo_q, s3_tmo_d;
  // digit stages
  logic                         dg_trig_q [NumDivStages];
  logic                         dg_vres_q [NumDivStages];
  logic [urc_pkg::RangeW-1:0]   dg_dist_q [NumDivStages];
  logic                         dg_oor_q  [NumDivStages];
  logic                         dg_tmo_q  [NumDivStages];
  logic [urc_pkg::RangeW-1:0]   dg_rem_q  [NumDivStages];
  logic [urc_pkg::DigitW-1:0]   dg_dig_q  [NumDivStages][urc_pkg::NumDigits];
  logic [urc_pkg::RangeW-1:0]   dg_rem_in [NumDivStages];
  logic [urc_pkg::RangeW-1:0]   dg_quo    [NumDivStages];
  logic [urc_pkg::DigitW-1:0]   dg_dig    [NumDivStages];

  // whole pipeline moves unless the last result is stuck
  assign adv     = !vld_q[NumStages-1] || pop_i;
  assign q_pop_o = adv && !q_empty_i;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], !q_empty_i};
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_trig_q <= q_item_i.trig;
      s1_kind_q <= q_item_i.kind;
      s1_x_q    <= {{(urc_pkg::ScaledW-urc_pkg::WidthW){1'b0}}, q_item_i.width}
                   * urc_pkg::ScaleMul;
    end
  end

  // stage 2
  assign s2_prod = {{urc_pkg::RecipW{1'b0}}, s1_x_q}
                 * {{urc_pkg::ScaledW{1'b0}}, urc_pkg::RecipMul};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_trig_q <= s1_trig_q;
      s2_kind_q <= s1_kind_q;
      s2_d_q    <= s2_prod[urc_pkg::RecipShift +: urc_pkg::DistW];
    end
  end

  // stage 3
  always_comb begin
    s3_trig_d = s2_trig_q;
    s3_vres_d = 1'b0;
    s3_dist_d = '0;
    s3_oor_d  = 1'b0;
    s3_tmo_d  = 1'b0;
    unique case (s2_kind_q)
      urc_pkg::KindEcho: begin
        s3_vres_d = 1'b1;
        if (s2_d_q > {1'b0, max_range_i}) begin
          s3_dist_d = max_range_i;
          s3_oor_d  = 1'b1;
        end else begin
          s3_dist_d = s2_d_q[urc_pkg::RangeW-1:0];
        end
      end
      urc_pkg::KindTimeout: begin
        s3_vres_d = 1'b1;
        s3_dist_d = max_range_i;
        s3_oor_d  = 1'b1;
        s3_tmo_d  = 1'b1;
      end
      default: begin
        s3_vres_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_trig_q <= s3_trig_d;
      s3_vres_q <= s3_vres_d;
      s3_dist_q <= s3_dist_d;
      s3_oor_q  <= s3_oor_d;
      s3_tmo_q  <= s3_tmo_d;
    end
  end

  // digit stages: each peels off the lowest decimal digit
  always_comb begin
    logic [TenProdW-1:0] prod;
    logic [urc_pkg::RangeW+3:0] ten_q;
    for (int k = 0; k < NumDivStages; k++) begin
      dg_rem_in[k] = (k == 0) ? s3_dist_q : dg_rem_q[(k == 0) ? 0 : k-1];
      prod = {{urc_pkg::TenW{1'b0}}, dg_rem_in[k]}
           * {{urc_pkg::RangeW{1'b0}}, urc_pkg::TenMul};
      dg_quo[k] = urc_pkg::RangeW'(prod[TenProdW-1:urc_pkg::TenShift]);
      ten_q = {1'b0, dg_quo[k], 3'b000} + {3'b000, dg_quo[k], 1'b0};
      dg_dig[k] = urc_pkg::DigitW'(dg_rem_in[k] - ten_q[urc_pkg::RangeW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumDivStages; k++) begin
        if (k == 0) begin
          dg_trig_q[k] <= s3_trig_q;
          dg_vres_q[k] <= s3_vres_q;
          dg_dist_q[k] <= s3_dist_q;
          dg_oor_q[k]  <= s3_oor_q;
          dg_tmo_q[k]  <= s3_tmo_q;
          for (int j = 0; j < urc_pkg::NumDigits; j++) begin
            dg_dig_q[k][j] <= (j == int'(urc_pkg::NumDigits) - 1 - k) ? dg_dig[k] : '0;
          end
        end else begin
          dg_trig_q[k] <= dg_trig_q[k-1];
          dg_vres_q[k] <= dg_vres_q[k-1];
          dg_dist_q[k] <= dg_dist_q[k-1];
          dg_oor_q[k]  <= dg_oor_q[k-1];
          dg_tmo_q[k]  <= dg_tmo_q[k-1];
          for (int j = 0; j < urc_pkg::NumDigits; j++) begin
            dg_dig_q[k][j] <= (j == int'(urc_pkg::NumDigits) - 1 - k) ? dg_dig[k]
                                                                     : dg_dig_q[k-1][j];
          end
        end
        dg_rem_q[k] <= dg_quo[k];
      end
    end
  end

  // output register is the last digit stage
  assign empty_o     = !vld_q[NumStages-1];
  assign trig_o      = dg_trig_q[NumDivStages-1];
  assign res_valid_o = dg_vres_q[NumDivStages-1];
  assign dist_o      = dg_dist_q[NumDivStages-1];
  assign oor_o       = dg_oor_q[NumDivStages-1];
  assign tmo_o       = dg_tmo_q[NumDivStages-1];

  // the remaining quotient is the top digit
  always_comb begin
    for (int j = 1; j < urc_pkg::NumDigits; j++) begin
      digits_o[j] = dg_dig_q[NumDivStages-1][j];
    end
    digits_o[0] = urc_pkg::DigitW'(dg_rem_q[NumDivStages-1]);
  end

endmodule

`default_nettype wire

// File: design/ultrasonic_ranger_controller_core.sv
// top level of the ultrasonic ranger controller: registers, front, queue, back
//
// channel   beat handshake           payload
// input     push & !full             echo_level_i
// result    pop & !empty             trigger_level_o .. digit_hundredths_cm_o
// config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// one tick per cycle if push & !full; front counters update in the cycle of the beat
// a result reaches the result ports through the queue and seven back stages
// the back pipeline holds as a whole only while its last result is not popped
// a four-entry queue lets the front keep taking ticks while the back is stalled
// reset starts in the trigger phase with all counters clear; config is always ready
`default_nettype none

module ultrasonic_ranger_controller_core #(
  parameter int unsigned FifoDepth = urc_pkg::FifoDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tick input
  input  wire logic                               push,
  output      logic                               full,
  input  wire logic                               echo_level_i,
  // result output
  output      logic                               empty,
  input  wire logic                               pop,
  output      logic                               trigger_level_o,
  output      logic                               result_valid_o,
  output      logic [urc_pkg::RangeW-1:0]         distance_centi_cm_o,
  output      logic                               out_of_range_o,
  output      logic                               timed_out_o,
  output      logic [urc_pkg::DigitW-1:0]         digit_hundreds_cm_o,
  output      logic [urc_pkg::DigitW-1:0]         digit_tens_cm_o,
  output      logic [urc_pkg::DigitW-1:0]         digit_units_cm_o,
  output      logic [urc_pkg::DigitW-1:0]         digit_tenths_cm_o,
  output      logic [urc_pkg::DigitW-1:0]         digit_hundredths_cm_o,
  // configuration writes
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [urc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [urc_pkg::WaitW-1:0]          cfg_data_i
);

  logic [urc_pkg::TrigW-1:0]  trig_ticks_q;
  logic [urc_pkg::WaitW-1:0]  wait_ticks_q;
  logic [urc_pkg::RangeW-1:0] max_range_q;

  logic             fq_push, fq_full, fq_pop, fq_empty;
  urc_pkg::item_t   fq_in, fq_out;
  logic [urc_pkg::DigitW-1:0] digits [urc_pkg::NumDigits];

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= urc_pkg::TrigReset;
      wait_ticks_q <= urc_pkg::WaitReset;
      max_range_q  <= urc_pkg::RangeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (urc_pkg::cfg_idx_e'(cfg_index_i))
        urc_pkg::CfgTrigger: trig_ticks_q <= cfg_data_i[urc_pkg::TrigW-1:0];
        urc_pkg::CfgWait:    wait_ticks_q <= cfg_data_i;
        urc_pkg::CfgRange:   max_range_q  <= cfg_data_i[urc_pkg::RangeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: sequencing and measurement
  urc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .echo_i          (echo_level_i),
    .trigger_ticks_i (trig_ticks_q),
    .wait_ticks_i    (wait_ticks_q),
    .q_full_i        (fq_full),
    .q_push_o        (fq_push),
    .q_item_o        (fq_in)
  );

  assign full = fq_full;

  // queue between front and back
  urc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .item_o  (fq_out)
  );

  // back: distance and digits
  urc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (fq_empty),
    .q_item_i    (fq_out),
    .q_pop_o     (fq_pop),
    .max_range_i (max_range_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .trig_o      (trigger_level_o),
    .res_valid_o (result_valid_o),
    .dist_o      (distance_centi_cm_o),
    .oor_o       (out_of_range_o),
    .tmo_o       (timed_out_o),
    .digits_o    (digits)
  );

  assign digit_hundreds_cm_o   = digits[0];
  assign digit_tens_cm_o       = digits[1];
  assign digit_units_cm_o      = digits[2];
  assign digit_tenths_cm_o     = digits[3];
  assign digit_hundredths_cm_o = digits[4];

endmodule

`default_nettype wire
